### src/next_permutation_generator_assert.svh
// Assertion macros used by the permutation generator datapath.
`ifndef NEXT_PERMUTATION_GENERATOR_ASSERT_SVH
`define NEXT_PERMUTATION_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define NPG_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define NPG_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/npg_pkg.sv
// Types and constants of the next permutation generator.
package npg_pkg;

   localparam int NPG_MAX_ELEMS   = 16;
   localparam int ELEM_W          = 4;
   localparam int COUNT_W         = 5;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd4;

   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam logic CSR_ELEM_COUNT = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT,
      ST_SWAP,
      ST_REV_RD,
      ST_REV_LO,
      ST_REV_HI
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_SCAN_FIRST,
      DP_SCAN,
      DP_EMIT_FIRST,
      DP_EMIT,
      DP_SWAP,
      DP_REV_FIRST,
      DP_REV_LO,
      DP_REV_HI
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_stop;
      logic slot_free;
      logic emit_last;
      logic wrapped;
      logic rev_single;
      logic rev_more;
   } dp_status_type;

endpackage

### src/npg_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module npg_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### src/npg_ctrl.sv
// Sequencer: scan, emit, swap and reverse steps of one item.
module npg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  npg_pkg::dp_status_type status,
   output npg_pkg::dp_cmd_type    cmd
);

   import npg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_stop) state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.slot_free && status.emit_last) begin
               state_in = status.wrapped ? ST_REV_RD : ST_SWAP;
            end
         end
         ST_SWAP: state_in = ST_REV_RD;
         ST_REV_RD: state_in = ST_REV_LO;
         ST_REV_LO: state_in = status.rev_single ? ST_IDLE : ST_REV_HI;
         ST_REV_HI: state_in = status.rev_more ? ST_REV_LO : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = DP_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = DP_ACCEPT;
         end
         ST_SCAN_RD: cmd.op = DP_SCAN_FIRST;
         ST_SCAN:    cmd.op = DP_SCAN;
         ST_EMIT_RD: cmd.op = DP_EMIT_FIRST;
         ST_EMIT:    cmd.op = DP_EMIT;
         ST_SWAP:    cmd.op = DP_SWAP;
         ST_REV_RD:  cmd.op = DP_REV_FIRST;
         ST_REV_LO:  cmd.op = DP_REV_LO;
         ST_REV_HI:  cmd.op = DP_REV_HI;
         default:    cmd.op = DP_NOP;
      endcase
   end

endmodule

### src/npg_dp.sv
// Datapath: permutation store, scan and emit registers, result word register.
`include "next_permutation_generator_assert.svh"

module npg_dp #(
   parameter int MAX_ELEMS = npg_pkg::NPG_MAX_ELEMS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  npg_pkg::dp_cmd_type              cmd,
   output npg_pkg::dp_status_type           status,
   input  logic                             req_restart,
   input  logic [$clog2(MAX_ELEMS+1)-1:0]   count_n,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [npg_pkg::ELEM_W-1:0]       rsp_element_value,
   output logic                             rsp_element_last,
   output logic                             rsp_sequence_wrapped
);

   import npg_pkg::*;

   localparam int AW    = $clog2(MAX_ELEMS);
   localparam int CNT_W = $clog2(MAX_ELEMS+1);

   logic [MAX_ELEMS-1:0] valid_ff, valid_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, wr_data;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [AW-1:0] ram_q_a, ram_q_b;

   logic          rd_valid_a_ff, rd_valid_a_in, rd_valid_b_ff, rd_valid_b_in;
   logic [AW-1:0] rd_addr_a_ff, rd_addr_a_in, rd_addr_b_ff, rd_addr_b_in;
   logic [AW-1:0] q_a, q_b;

   logic [CNT_W-1:0] k_ff, k_in, i_ff, i_in;
   logic [AW-1:0]    prev_ff, prev_in, pivot_ff, pivot_in;
   logic [AW-1:0]    j_ff, j_in, aj_ff, aj_in;
   logic [AW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic             wrapped_ff, wrapped_in, j_found_ff, j_found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in, rsp_wrap_ff, rsp_wrap_in;

   logic [CNT_W-1:0] k_inc, last_idx, i_dec;
   logic [AW-1:0]    hi_init, lo_inc, hi_dec, hi_minus_lo, sub_lo, sub_hi;
   logic             at_last, descent, slot_free;

   npg_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_ELEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_q_a),
      .rd_data_b (ram_q_b)
   );

   // Entries never written since restart read as identity.
   assign q_a = rd_valid_a_ff ? ram_q_a : rd_addr_a_ff;
   assign q_b = rd_valid_b_ff ? ram_q_b : rd_addr_b_ff;

   assign k_inc       = k_ff + 1'b1;
   assign last_idx    = count_n - 1'b1;
   assign i_dec       = i_ff - 1'b1;
   assign at_last     = (k_ff == last_idx);
   assign descent     = (k_ff != '0) && !(q_a > prev_ff);
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign hi_init     = wrapped_ff ? last_idx[AW-1:0] : i_dec[AW-1:0];
   assign lo_inc      = lo_ff + 1'b1;
   assign hi_dec      = hi_ff - 1'b1;
   assign hi_minus_lo = hi_ff - lo_ff;

   // Reversal reads the old store; the swap partner slot reads as the pivot.
   assign sub_lo = (!wrapped_ff && hi_ff == j_ff) ? pivot_ff : q_b;
   assign sub_hi = (!wrapped_ff && lo_ff == j_ff) ? pivot_ff : q_a;

   always_comb begin
      valid_in      = valid_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      k_in          = k_ff;
      i_in          = i_ff;
      prev_in       = prev_ff;
      pivot_in      = pivot_ff;
      j_in          = j_ff;
      aj_in         = aj_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wrapped_in    = wrapped_ff;
      j_found_in    = j_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_wrap_in   = rsp_wrap_ff;

      unique case (cmd.op)
         DP_NOP: ;
         DP_ACCEPT: begin
            if (req_restart) valid_in = '0;
         end
         DP_SCAN_FIRST: begin
            k_in  = '0;
            rd_en = 1'b1;
         end
         DP_SCAN: begin
            prev_in = q_a;
            if (descent) begin
               i_in       = k_ff;
               pivot_in   = q_a;
               wrapped_in = 1'b0;
            end else if (at_last) begin
               i_in       = count_n;
               wrapped_in = 1'b1;
            end else begin
               k_in      = k_inc;
               rd_en     = 1'b1;
               rd_addr_a = k_inc[AW-1:0];
            end
         end
         DP_EMIT_FIRST: begin
            k_in       = '0;
            j_found_in = 1'b0;
            rd_en      = 1'b1;
         end
         DP_EMIT: begin
            // hold the read data until the result register frees up
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ELEM_W'(q_a);
               rsp_last_in  = at_last;
               rsp_wrap_in  = wrapped_ff;
               if (!j_found_ff && !wrapped_ff && (k_ff < i_ff) && !(q_a < pivot_ff)) begin
                  j_found_in = 1'b1;
                  j_in       = k_ff[AW-1:0];
                  aj_in      = q_a;
               end
               if (!at_last) begin
                  k_in      = k_inc;
                  rd_en     = 1'b1;
                  rd_addr_a = k_inc[AW-1:0];
               end
            end
         end
         DP_SWAP: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[AW-1:0];
            wr_data = aj_ff;
         end
         DP_REV_FIRST: begin
            lo_in     = '0;
            hi_in     = hi_init;
            rd_en     = 1'b1;
            rd_addr_b = hi_init;
         end
         DP_REV_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = sub_lo;
         end
         DP_REV_HI: begin
            wr_en     = 1'b1;
            wr_addr   = hi_ff;
            wr_data   = sub_hi;
            lo_in     = lo_inc;
            hi_in     = hi_dec;
            rd_en     = 1'b1;
            rd_addr_a = lo_inc;
            rd_addr_b = hi_dec;
         end
         default: ;
      endcase

      if (wr_en) valid_in[wr_addr] = 1'b1;
   end

   assign rd_valid_a_in = rd_en ? valid_ff[rd_addr_a] : rd_valid_a_ff;
   assign rd_valid_b_in = rd_en ? valid_ff[rd_addr_b] : rd_valid_b_ff;
   assign rd_addr_a_in  = rd_en ? rd_addr_a : rd_addr_a_ff;
   assign rd_addr_b_in  = rd_en ? rd_addr_b : rd_addr_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_a_ff <= rd_valid_a_in;
      rd_valid_b_ff <= rd_valid_b_in;
      rd_addr_a_ff  <= rd_addr_a_in;
      rd_addr_b_ff  <= rd_addr_b_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      prev_ff       <= prev_in;
      pivot_ff      <= pivot_in;
      j_ff          <= j_in;
      aj_ff         <= aj_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      wrapped_ff    <= wrapped_in;
      j_found_ff    <= j_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_wrap_ff   <= rsp_wrap_in;
   end

   assign status.scan_stop  = descent || at_last;
   assign status.slot_free  = slot_free;
   assign status.emit_last  = at_last;
   assign status.wrapped    = wrapped_ff;
   assign status.rev_single = (lo_ff == hi_ff);
   assign status.rev_more   = (hi_minus_lo > AW'(1));

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_element_value    = rsp_value_ff;
   assign rsp_element_last     = rsp_last_ff;
   assign rsp_sequence_wrapped = rsp_wrap_ff;

   `NPG_ASSERT_IMP(a_swap_has_partner, cmd.op == DP_SWAP, j_found_ff && !wrapped_ff, "swap without a partner element")
   `NPG_ASSERT_IMP(a_rev_pair_ordered, cmd.op == DP_REV_HI, hi_ff > lo_ff, "reversal pair crossed")
   `NPG_ASSERT_NXT(a_descent_in_prefix, cmd.op == DP_SCAN && descent, (i_ff != '0) && (i_ff < count_n), "descent index out of prefix")

endmodule

### src/next_permutation_generator.sv
// Top level of the next permutation generator: config register, sequencer and datapath.
//
// Each accepted word steps a stored permutation of n = elem_count values (clamped to
// 2..MAX_ELEMS) in mirrored Narayana order: the current permutation goes out as n result
// words in position order, the last one flagged, then the store advances (first descent,
// swap with the first larger prefix element, prefix reversal; full reversal when there is
// no descent, flagged on every word as sequence_wrapped). restart=1 reloads identity order
// first. An item passes through an accept step, a scan, emission, a swap (skipped on a
// wrap), and a reversal that reads first and then writes the elements one at a time. The
// steps run in series on the single store, a RAM with one write and two read ports.
// One item is in work at a time; the next is accepted while the last result word still
// waits in the output register.
// elem_count sits at byte address 0 of the register port and resets to 4.
module next_permutation_generator #(
   parameter int MAX_ELEMS = npg_pkg::NPG_MAX_ELEMS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [npg_pkg::ELEM_W-1:0]       rsp_element_value,
   output logic                             rsp_element_last,
   output logic                             rsp_sequence_wrapped,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [npg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [npg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [npg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import npg_pkg::*;

   localparam int CNT_W = $clog2(MAX_ELEMS+1);

   logic [COUNT_W-1:0] elem_count_ff, elem_count_in;
   logic [CNT_W-1:0]   count_n;
   logic               csr_hit;
   dp_cmd_type         cmd;
   dp_status_type      status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_ELEM_COUNT);

   always_comb begin
      elem_count_in = elem_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         elem_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_count_ff <= COUNT_RESET;
      end else begin
         elem_count_ff <= elem_count_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(elem_count_ff) : '0;

   // clamp the count into 2..MAX_ELEMS
   always_comb begin
      if (elem_count_ff < COUNT_W'(2)) begin
         count_n = CNT_W'(2);
      end else if (32'(elem_count_ff) > MAX_ELEMS) begin
         count_n = CNT_W'(MAX_ELEMS);
      end else begin
         count_n = CNT_W'(elem_count_ff);
      end
   end

   npg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   npg_dp #(
      .MAX_ELEMS (MAX_ELEMS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_restart          (req_restart),
      .count_n              (count_n),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_element_value    (rsp_element_value),
      .rsp_element_last     (rsp_element_last),
      .rsp_sequence_wrapped (rsp_sequence_wrapped)
   );

endmodule
